[rtl/core/psect_pkg.sv]
// Shared types and codes for the per-sender event counter table.
package psect_pkg;

  localparam int unsigned SenderW = 22;
  localparam int unsigned CountW  = 32;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned StatusW = 2;

  localparam logic       OpEvent  = 1'b0;
  localparam logic       OpReport = 1'b1;

  localparam logic       KindAck  = 1'b0;
  localparam logic       KindRow  = 1'b1;

  localparam logic       SigFirst = 1'b0;

  localparam logic [StatusW-1:0] StatExisting = 2'd0;
  localparam logic [StatusW-1:0] StatNew      = 2'd1;
  localparam logic [StatusW-1:0] StatFull     = 2'd2;

  typedef struct packed {
    logic [SenderW-1:0] sender;
    logic [CountW-1:0]  first;
    logic [CountW-1:0]  second;
  } entry_t;

  // One result as decided by the head of the ring in the current cycle.
  typedef struct packed {
    logic               fire;
    logic               insert;
    logic               kind;
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    entry_t             entry;
    logic               row_valid;
    logic               last;
  } head_res_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == {CountW{1'b1}}) ? v : v + CountW'(1);
  endfunction

endpackage

[rtl/core/per_sender_event_counter_table.sv]
// Per-sender event counter table built as a ring of entry cells.
// Each request turns the ring once, visiting slots at the head in order; busy until it ends.
// Starts are taken only when idle; a result shows the cycle after its slot is at the head.
// An event gives one result, a report a row per used slot back to back, or one empty result.
// Reset clears the fill count and control; cell contents stay undefined until written.
module per_sender_event_counter_table
  import psect_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic [SenderW-1:0] sender_id_i,
  input  logic               signal_kind_i,
  output logic               valid_o,
  output logic               kind_o,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   slot_o,
  output logic [SenderW-1:0] sender_out_o,
  output logic [CountW-1:0]  count_first_o,
  output logic [CountW-1:0]  count_second_o,
  output logic               row_valid_o,
  output logic               last_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    step_q;
  logic [CntW-1:0]    used_q;
  logic               done_q;
  logic               op_q;
  logic [SenderW-1:0] sender_q;
  logic               sig_q;
  head_res_t          out_q;
  logic               valid_q;

  entry_t    ring[ENTRIES];
  entry_t    head_wr;
  head_res_t res;
  logic      running;

  assign running = state_q == StRun;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t feed;
    if (i == ENTRIES - 1) begin : g_tail
      assign feed = head_wr;
    end else begin : g_mid
      assign feed = ring[i+1];
    end
    psect_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (running),
      .entry_i (feed),
      .entry_o (ring[i])
    );
  end

  psect_head #(
    .ENTRIES (ENTRIES)
  ) u_head (
    .entry_i       (ring[0]),
    .step_i        (step_q),
    .used_i        (used_q),
    .done_i        (done_q),
    .op_i          (op_q),
    .sender_id_i   (sender_q),
    .signal_kind_i (sig_q),
    .entry_o       (head_wr),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StRun;
            step_q  <= '0;
            done_q  <= 1'b0;
          end
        end
        StRun: begin
          valid_q <= res.fire;
          if (res.fire && (op_q == OpEvent)) begin
            done_q <= 1'b1;
          end
          if (res.insert) begin
            used_q <= CntW'(used_q + CntW'(1));
          end
          if (step_q == CntW'(ENTRIES - 1)) begin
            state_q <= StIdle;
          end else begin
            step_q <= CntW'(step_q + CntW'(1));
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Request fields and the result payload need no reset.
  always_ff @(posedge clk_i) begin
    if (!running && start_i) begin
      op_q     <= op_i;
      sender_q <= sender_id_i;
      sig_q    <= signal_kind_i;
    end
    if (running && res.fire) begin
      out_q <= res;
    end
  end

  assign busy_o         = running;
  assign valid_o        = valid_q;
  assign kind_o         = out_q.kind;
  assign status_o       = out_q.status;
  assign slot_o         = out_q.slot;
  assign sender_out_o   = out_q.entry.sender;
  assign count_first_o  = out_q.entry.first;
  assign count_second_o = out_q.entry.second;
  assign row_valid_o    = out_q.row_valid;
  assign last_o         = out_q.last;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(ENTRIES))
    else $error("fill count exceeds table depth");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (kind_o == KindAck) |-> last_o && !row_valid_o)
    else $error("event acknowledgement not marked last");

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result without a pass in progress");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != $past(used_q) |-> used_q == CntW'($past(used_q) + CntW'(1)))
    else $error("fill count changed by other than one");
`endif

endmodule

[rtl/core/psect_cell.sv]
// One table cell of the ring: holds an entry and passes it on while the ring turns.
module psect_cell
  import psect_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

[rtl/core/psect_head.sv]
// Head of the ring: sender compare, counter update and result selection.
module psect_head
  import psect_pkg::*;
#(
  parameter int unsigned ENTRIES = 64,
  localparam int unsigned CntW   = $clog2(ENTRIES + 1)
) (
  input  entry_t              entry_i,
  input  logic [CntW-1:0]     step_i,
  input  logic [CntW-1:0]     used_i,
  input  logic                done_i,
  input  logic                op_i,
  input  logic [SenderW-1:0]  sender_id_i,
  input  logic                signal_kind_i,
  output entry_t              entry_o,
  output head_res_t           res_o
);

  logic   occupied;
  logic   match;
  logic   at_end;
  entry_t bumped;
  entry_t fresh;

  assign occupied = step_i < used_i;
  assign match    = occupied && (entry_i.sender == sender_id_i);
  assign at_end   = step_i == CntW'(ENTRIES - 1);

  always_comb begin
    bumped = entry_i;
    if (signal_kind_i == SigFirst) begin
      bumped.first = sat_inc(entry_i.first);
    end else begin
      bumped.second = sat_inc(entry_i.second);
    end
    fresh.sender = sender_id_i;
    fresh.first  = (signal_kind_i == SigFirst) ? CountW'(1) : '0;
    fresh.second = (signal_kind_i == SigFirst) ? '0 : CountW'(1);
  end

  always_comb begin
    entry_o         = entry_i;
    res_o.fire      = 1'b0;
    res_o.insert    = 1'b0;
    res_o.kind      = op_i;
    res_o.status    = StatExisting;
    res_o.slot      = SlotW'(step_i);
    res_o.entry     = entry_i;
    res_o.row_valid = 1'b0;
    res_o.last      = 1'b1;
    if (op_i == OpEvent) begin
      // Slots are visited in order, so reaching the first free slot without a
      // hit proves the sender is new.
      if (!done_i) begin
        priority if (match) begin
          entry_o     = bumped;
          res_o.fire  = 1'b1;
          res_o.entry = bumped;
        end else if (step_i == used_i) begin
          entry_o      = fresh;
          res_o.fire   = 1'b1;
          res_o.insert = 1'b1;
          res_o.status = StatNew;
          res_o.entry  = fresh;
        end else if (at_end) begin
          res_o.fire         = 1'b1;
          res_o.status       = StatFull;
          res_o.slot         = '0;
          res_o.entry.sender = sender_id_i;
          res_o.entry.first  = '0;
          res_o.entry.second = '0;
        end
      end
    end else begin
      if (used_i == '0) begin
        res_o.fire  = step_i == '0;
        res_o.entry = '0;
      end else if (occupied) begin
        res_o.fire      = 1'b1;
        res_o.row_valid = 1'b1;
        res_o.last      = step_i == CntW'(used_i - CntW'(1));
      end
    end
  end

endmodule
